FILE: rtl/d2x_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2x_pkg: shared types and constants for disparity to xyz reprojection
// Fixed widths of the divider datapath, register indexes and range limits.
// ----------------------------------------------------------------------------
package d2x_pkg;

   // dividend is (product + 8*D) >> 4, divisor is the raw disparity code
   localparam int NUM_W   = 29;
   localparam int DEN_W   = 16;
   localparam int QUO_W   = 20;
   localparam int DIV_LAT = QUO_W + 1;

   localparam int CFG_W   = 16;
   localparam int XY_W    = 20;
   localparam int Z_W     = 16;

   localparam logic [XY_W-1:0]  XY_POS_MAX = 20'h7FFFF;
   localparam logic [XY_W-1:0]  XY_NEG_MIN = 20'h80000;
   localparam logic [Z_W-1:0]   Z_MAX      = 16'd40960;
   localparam logic [DEN_W-1:0] SMALL_D    = 16'd16;

   typedef enum logic [1:0] {
      CSR_FOCAL    = 2'd0,
      CSR_BASELINE = 2'd1,
      CSR_CENTER_U = 2'd2,
      CSR_CENTER_V = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic             big;
      logic [QUO_W-1:0] quo;
   } div_res_type;

   typedef struct packed {
      logic valid;
      logic invalid;
      logic neg_x;
      logic neg_y;
   } side_type;

endpackage
`default_nettype wire

FILE: rtl/d2x_div_pipe.sv
`default_nettype none
// ----------------------------------------------------------------------------
// d2x_div_pipe: pipelined restoring divider
// One quotient bit per register stage. The first stage flags a quotient of
// 2**QUO_W or more; the low QUO_W quotient bits follow QUO_W stages later.
// ----------------------------------------------------------------------------
module d2x_div_pipe (
   input  wire logic                        clock,
   input  wire logic [d2x_pkg::NUM_W-1:0]   num,
   input  wire logic [d2x_pkg::DEN_W-1:0]   den,
   output      d2x_pkg::div_res_type        res
);
   import d2x_pkg::*;

   logic [DEN_W-1:0] rem_ff [DIV_LAT];
   logic [DEN_W-1:0] rem_in [DIV_LAT];
   logic [DEN_W-1:0] den_ff [DIV_LAT];
   logic [DEN_W-1:0] den_in [DIV_LAT];
   logic [QUO_W-1:0] low_ff [DIV_LAT];
   logic [QUO_W-1:0] low_in [DIV_LAT];
   logic [QUO_W-1:0] quo_ff [DIV_LAT];
   logic [QUO_W-1:0] quo_in [DIV_LAT];
   logic             big_ff [DIV_LAT];
   logic             big_in [DIV_LAT];
   logic [DEN_W:0]   trial  [DIV_LAT];
   logic             ge     [DIV_LAT];

   always_comb begin
      rem_in[0] = DEN_W'(num[NUM_W-1:QUO_W]);
      big_in[0] = DEN_W'(num[NUM_W-1:QUO_W]) >= den;
      low_in[0] = num[QUO_W-1:0];
      quo_in[0] = '0;
      den_in[0] = den;
      trial[0]  = '0;
      ge[0]     = 1'b0;
      for (int k = 1; k < DIV_LAT; k++) begin
         // shift in the next dividend bit, subtract where it fits
         trial[k]  = {rem_ff[k-1], low_ff[k-1][QUO_W-1]};
         ge[k]     = trial[k] >= {1'b0, den_ff[k-1]};
         rem_in[k] = ge[k] ? DEN_W'(trial[k] - {1'b0, den_ff[k-1]}) : trial[k][DEN_W-1:0];
         low_in[k] = {low_ff[k-1][QUO_W-2:0], 1'b0};
         quo_in[k] = {quo_ff[k-1][QUO_W-2:0], ge[k]};
         den_in[k] = den_ff[k-1];
         big_in[k] = big_ff[k-1];
      end
   end

   always_ff @(posedge clock) begin
      for (int k = 0; k < DIV_LAT; k++) begin
         rem_ff[k] <= rem_in[k];
         den_ff[k] <= den_in[k];
         low_ff[k] <= low_in[k];
         quo_ff[k] <= quo_in[k];
         big_ff[k] <= big_in[k];
      end
   end

   assign res = {big_ff[DIV_LAT-1], quo_ff[DIV_LAT-1]};

endmodule
`default_nettype wire

FILE: rtl/disparity_to_xyz_top.sv
`default_nettype none
// ----------------------------------------------------------------------------
// disparity_to_xyz_top: stereo disparity to 3-D point reprojection
// Depth is focal*baseline/disparity; x and y are scaled from the principal
// point offset, rounded to nearest and saturated, zero for invalid points.
// ----------------------------------------------------------------------------
// Usage:
//  - Input: drive req_disparity, req_column and req_row with start high; the
//    beat is taken at any edge with busy low. busy is always low, so a new
//    pixel may be given every clock.
//  - Output: one result per beat, shown for one cycle with rsp_strobe high,
//    in input order. The receiver cannot stall the block.
//  - Pipeline: the three-stage front end (register, multiply, round/compare),
//    the 21-stage bit-per-stage divider and the output register. Throughput:
//    one pixel per cycle.
//  - Configuration: csr_we with csr_index and csr_wdata writes focal length,
//    baseline or principal point; write only while no beat is in flight.
//  - Reset: synchronous, clears all beats in flight and restores register
//    defaults. No clearing pass is needed.
// ----------------------------------------------------------------------------
module disparity_to_xyz_top #(
   parameter int MAX_COLS = 2048,
   parameter int MAX_ROWS = 2048
) (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          start,
   output      logic                          busy,
   input  wire logic [15:0]                   req_disparity,
   input  wire logic [10:0]                   req_column,
   input  wire logic [10:0]                   req_row,
   output      logic                          rsp_strobe,
   output      logic signed [d2x_pkg::XY_W-1:0] rsp_x_metres,
   output      logic signed [d2x_pkg::XY_W-1:0] rsp_y_metres,
   output      logic [d2x_pkg::Z_W-1:0]       rsp_z_metres,
   output      logic                          rsp_point_valid,
   input  wire logic                          csr_we,
   input  wire logic [1:0]                    csr_index,
   input  wire logic [d2x_pkg::CFG_W-1:0]     csr_wdata
);
   import d2x_pkg::*;

   localparam int LAT = DIV_LAT + 4;

   function automatic logic [XY_W-1:0] sat_xy(input div_res_type r, input logic neg);
      logic [XY_W-1:0] v;
      if (!neg) begin
         v = (r.big || r.quo[XY_W-1]) ? XY_POS_MAX : r.quo;
      end else begin
         v = (r.big || (r.quo > XY_NEG_MIN)) ? XY_NEG_MIN : XY_W'(~r.quo + 1'b1);
      end
      return v;
   endfunction

   // configuration
   logic [CFG_W-1:0] focal_ff, baseline_ff, center_u_ff, center_v_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         focal_ff    <= 16'd11200;
         baseline_ff <= 16'd7864;
         center_u_ff <= 16'd5120;
         center_v_ff <= 16'd3840;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_FOCAL:    focal_ff    <= csr_wdata;
            CSR_BASELINE: baseline_ff <= csr_wdata;
            CSR_CENTER_U: center_u_ff <= csr_wdata;
            CSR_CENTER_V: center_v_ff <= csr_wdata;
            default: ;
         endcase
      end
   end

   assign busy = 1'b0;

   // stage 1: offsets from the principal point as sign and magnitude
   logic             accept;
   logic [16:0]      diff_x, diff_y;
   logic             v1_ff, oof1_ff, negx1_ff, negy1_ff;
   logic [15:0]      d1_ff, magx1_ff, magy1_ff;

   assign accept = start && !busy;
   assign diff_x = {1'b0, center_u_ff} - {2'b00, req_column, 4'b0000};
   assign diff_y = {1'b0, center_v_ff} - {2'b00, req_row, 4'b0000};

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff <= 1'b0;
      end else begin
         v1_ff <= accept;
      end
      d1_ff    <= req_disparity;
      oof1_ff  <= (32'(req_column) >= 32'(MAX_COLS)) || (32'(req_row) >= 32'(MAX_ROWS));
      negx1_ff <= diff_x[16];
      negy1_ff <= diff_y[16];
      magx1_ff <= diff_x[16] ? 16'(~diff_x + 17'd1) : diff_x[15:0];
      magy1_ff <= diff_y[16] ? 16'(~diff_y + 17'd1) : diff_y[15:0];
   end

   // stage 2: products with the baseline
   logic             v2_ff, bad2_ff, negx2_ff, negy2_ff;
   logic [15:0]      d2_ff;
   logic [31:0]      fb2_ff, px2_ff, py2_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         v2_ff <= 1'b0;
      end else begin
         v2_ff <= v1_ff;
      end
      d2_ff    <= d1_ff;
      bad2_ff  <= oof1_ff || (d1_ff <= SMALL_D);
      negx2_ff <= negx1_ff;
      negy2_ff <= negy1_ff;
      fb2_ff   <= 32'(focal_ff) * 32'(baseline_ff);
      px2_ff   <= 32'(magx1_ff) * 32'(baseline_ff);
      py2_ff   <= 32'(magy1_ff) * 32'(baseline_ff);
   end

   // stage 3: add half the divisor for rounding, far-point compare
   logic [19:0]      d10;
   logic [32:0]      nz, nx, ny;
   logic [NUM_W-1:0] nz3_ff, nx3_ff, ny3_ff;
   logic [DEN_W-1:0] d3_ff;
   side_type         side3_ff;

   assign d10 = {1'b0, d2_ff, 3'b000} + {3'b000, d2_ff, 1'b0};
   assign nz  = {1'b0, fb2_ff} + {14'd0, d2_ff, 3'b000};
   assign nx  = {1'b0, px2_ff} + {14'd0, d2_ff, 3'b000};
   assign ny  = {1'b0, py2_ff} + {14'd0, d2_ff, 3'b000};

   always_ff @(posedge clock) begin
      if (reset) begin
         side3_ff.valid <= 1'b0;
      end else begin
         side3_ff.valid <= v2_ff;
      end
      side3_ff.invalid <= bad2_ff || ({4'h0, fb2_ff} > {d10, 16'h0000});
      side3_ff.neg_x   <= negx2_ff;
      side3_ff.neg_y   <= negy2_ff;
      nz3_ff <= nz[32:4];
      nx3_ff <= nx[32:4];
      ny3_ff <= ny[32:4];
      d3_ff  <= d2_ff;
   end

   // dividers, with flags carried alongside
   div_res_type res_z, res_x, res_y;
   side_type    side_ff [DIV_LAT];

   d2x_div_pipe u_div_z (.clock(clock), .num(nz3_ff), .den(d3_ff), .res(res_z));
   d2x_div_pipe u_div_x (.clock(clock), .num(nx3_ff), .den(d3_ff), .res(res_x));
   d2x_div_pipe u_div_y (.clock(clock), .num(ny3_ff), .den(d3_ff), .res(res_y));

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int k = 0; k < DIV_LAT; k++) begin
            side_ff[k] <= '0;
         end
      end else begin
         side_ff[0] <= side3_ff;
         for (int k = 1; k < DIV_LAT; k++) begin
            side_ff[k] <= side_ff[k-1];
         end
      end
   end

   // output register
   side_type last;
   assign last = side_ff[DIV_LAT-1];

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_strobe <= 1'b0;
      end else begin
         rsp_strobe <= last.valid;
      end
      if (last.invalid) begin
         rsp_x_metres    <= '0;
         rsp_y_metres    <= '0;
         rsp_z_metres    <= '0;
         rsp_point_valid <= 1'b0;
      end else begin
         rsp_x_metres    <= sat_xy(res_x, last.neg_x);
         rsp_y_metres    <= sat_xy(res_y, last.neg_y);
         rsp_z_metres    <= res_z.quo[Z_W-1:0];
         rsp_point_valid <= 1'b1;
      end
   end

   a_strobe_from_beat: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe |-> $past(start && !busy, LAT))
      else $error("result without an accepted beat");

   a_z_range: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_point_valid |-> rsp_z_metres <= Z_MAX)
      else $error("depth above limit on valid point");

   a_invalid_zero: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && !rsp_point_valid |->
         rsp_x_metres == '0 && rsp_y_metres == '0 && rsp_z_metres == '0)
      else $error("invalid point with non-zero coordinates");

   a_small_disp: assert property (@(posedge clock) disable iff (reset)
      rsp_strobe && rsp_point_valid |-> $past(req_disparity, LAT) > SMALL_D)
      else $error("valid point from disparity of one pixel or less");

endmodule
`default_nettype wire
